[rtl/core/vertex_dedup_reindex_assert.svh]
// Assertion macros used by the checker of the vertex dedup block
`ifndef VERTEX_DEDUP_REINDEX_ASSERT_SVH
`define VERTEX_DEDUP_REINDEX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset
`define VDR_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset
`define VDR_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after reset is seen
`define VDR_ASSERT_AFTER_RESET(label, ck, rs, cons, msg) \
  label: assert property (@(posedge ck) (rs) |=> (cons)) else $error(msg);

`endif

[rtl/core/vdr_pkg.sv]
// Shared types, sizes and codes of the vertex dedup and reindex block
package vdr_pkg;

  // Capacity of one mesh level, in original points
  localparam int MAX_POINTS = 256;

  // Search lanes: stored points compared per cycle, one bank each
  localparam int LANES  = 4;
  localparam int LANE_W = $clog2(LANES);

  // Derived sizes of counters, addresses and banks
  localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int NROW   = (MAX_POINTS + LANES - 1) / LANES;
  localparam int RW     = (NROW > 1) ? $clog2(NROW) : 1;
  localparam int KW     = RW + LANE_W;

  // Fixed field widths
  localparam int COORD_W = 32;
  localparam int PT_W    = 3 * COORD_W;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int ST_W    = 2;
  localparam int CMP_W   = (CW > IDX_W) ? CW : IDX_W;

  // Command queue between front and back (depth a power of two)
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // Operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_REMAP = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REMAP,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]          orig_index;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] new_index;
    logic             is_duplicate;
    logic [CNT_W-1:0] distinct_count;
    logic [ST_W-1:0]  status;
  } result_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PT_W-1:0]  pos;
    logic [IDX_W-1:0] oi;
  } cmd_t;

endpackage

[rtl/core/vdr_ram.sv]
// Generic single-write, single-read RAM with registered read data
module vdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/vdr_front.sv]
// Front end: accepts input transactions, classifies them and queues commands
module vdr_front import vdr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_take
);

  cmd_t             q [CQ_DEPTH];
  logic [CQ_PW-1:0] wptr;
  logic [CQ_PW-1:0] rptr;
  logic [CQ_CW-1:0] count;
  cmd_t             decoded;
  logic             do_push;

  // Classify the incoming operation
  always_comb begin
    decoded.pos = {item.pos_x, item.pos_y, item.pos_z};
    decoded.oi  = item.orig_index;
    unique case (item.operation)
      OP_ADD:   decoded.kind = CMD_ADD;
      OP_REMAP: decoded.kind = CMD_REMAP;
      OP_CLEAR: decoded.kind = CMD_CLEAR;
      OP_NONE:  decoded.kind = CMD_NOP;
    endcase
  end

  assign full      = (count == CQ_CW'(CQ_DEPTH));
  assign do_push   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= decoded;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (cmd_take) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, cmd_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/vdr_back.sv]
// Back end: searches the point store, appends, remaps, clears and holds the result
module vdr_back import vdr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_pop
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REMAP
  } state_t;

  state_t           state;
  logic [CW-1:0]    points_seen;
  logic [CW-1:0]    distinct_seen;
  logic [RW-1:0]    row;
  logic [PT_W-1:0]  pos;

  logic [PT_W-1:0]  bank_rdata [LANES];
  logic [LANES-1:0] bank_we;
  logic [RW-1:0]    bank_waddr;
  logic [RW-1:0]    bank_raddr;
  logic [PT_W-1:0]  pt_wdata;
  logic             rm_we;
  logic [IDX_W-1:0] rm_wdata;
  logic [IDX_W-1:0] rm_rdata;

  logic             slot_free;
  logic             table_full;
  logic             oi_bad;
  logic [LANES-1:0] lane_hit;
  logic             hit_any;
  logic [LANE_W-1:0] hit_lane;
  logic [KW-1:0]    hit_k;
  logic             search_last;
  logic             do_append;
  logic             do_hit;
  logic             res_set;

  function automatic result_t mk_res(logic [IDX_W-1:0] idx, logic dup,
                                     logic [CNT_W-1:0] cnt, logic [ST_W-1:0] st);
    result_t r;
    r.new_index      = idx;
    r.is_duplicate   = dup;
    r.distinct_count = cnt;
    r.status         = st;
    return r;
  endfunction

  // Point store, interleaved over the lanes by the low index bits
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    vdr_ram #(.WIDTH(PT_W), .DEPTH(NROW)) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr),
      .wdata (pt_wdata),
      .raddr (bank_raddr),
      .rdata (bank_rdata[b])
    );
  end

  // Compact index per original index
  vdr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_remap (
    .clk   (clk),
    .we    (rm_we),
    .waddr (points_seen[PIDX_W-1:0]),
    .wdata (rm_wdata),
    .raddr (PIDX_W'(cmd.oi)),
    .rdata (rm_rdata)
  );

  // Take a command only when the result slot will be free for it
  assign slot_free  = !out_valid || out_pop;
  assign cmd_take   = (state == S_IDLE) && cmd_valid && slot_free;
  assign table_full = (points_seen >= CW'(MAX_POINTS));
  assign oi_bad     = (CMP_W'(cmd.oi) >= CMP_W'(points_seen));

  // Compare one row of stored points, lowest lane first
  always_comb begin
    hit_lane = '0;
    for (int b = 0; b < LANES; b++) begin
      lane_hit[b] = (bank_rdata[b] == pos) &&
                    (CW'({row, LANE_W'(b)}) < distinct_seen);
    end
    for (int b = LANES - 1; b >= 0; b--) begin
      if (lane_hit[b]) begin
        hit_lane = LANE_W'(b);
      end
    end
  end

  assign hit_any     = |lane_hit;
  assign hit_k       = {row, hit_lane};
  assign search_last = ((CW + 1)'({row, {LANE_W{1'b0}}}) + (CW + 1)'(LANES))
                       >= (CW + 1)'(distinct_seen);

  // Decide appends and duplicate hits
  assign do_append = (cmd_take && (cmd.kind == CMD_ADD) && !table_full &&
                      (distinct_seen == '0)) ||
                     ((state == S_SEARCH) && !hit_any && search_last);
  assign do_hit    = (state == S_SEARCH) && hit_any;

  // Load the result register when a command finishes this cycle
  assign res_set = (cmd_take &&
                    !((cmd.kind == CMD_ADD) && !table_full && (distinct_seen != '0)) &&
                    !((cmd.kind == CMD_REMAP) && !oi_bad)) ||
                   ((state == S_SEARCH) && (hit_any || search_last)) ||
                   (state == S_REMAP);

  // Drive store writes and reads
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_we[b] = do_append && (distinct_seen[LANE_W-1:0] == LANE_W'(b));
    end
    bank_waddr = RW'(distinct_seen >> LANE_W);
    bank_raddr = (state == S_SEARCH) ? row + 1'b1 : '0;
    pt_wdata   = (state == S_IDLE) ? cmd.pos : pos;
    rm_we      = do_append || do_hit;
    rm_wdata   = do_hit ? IDX_W'(hit_k) : IDX_W'(distinct_seen);
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      points_seen   <= '0;
      distinct_seen <= '0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= res_set || (out_valid && !out_pop);
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            pos <= cmd.pos;
            row <= '0;
            unique case (cmd.kind)
              CMD_ADD: begin
                if (table_full) begin
                  out_res   <= mk_res('0, 1'b0, CNT_W'(distinct_seen), ST_FULL);
                end else if (distinct_seen == '0) begin
                  points_seen   <= points_seen + 1'b1;
                  distinct_seen <= distinct_seen + 1'b1;
                  out_res       <= mk_res('0, 1'b0,
                                          CNT_W'(distinct_seen + CW'(1)), ST_OK);
                end else begin
                  state <= S_SEARCH;
                end
              end
              CMD_REMAP: begin
                if (oi_bad) begin
                  out_res   <= mk_res('0, 1'b0, CNT_W'(distinct_seen), ST_RANGE);
                end else begin
                  state <= S_REMAP;
                end
              end
              CMD_CLEAR: begin
                points_seen   <= '0;
                distinct_seen <= '0;
                out_res       <= mk_res('0, 1'b0, '0, ST_OK);
              end
              CMD_NOP: begin
                out_res   <= mk_res('0, 1'b0, CNT_W'(distinct_seen), ST_OK);
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (hit_any) begin
            points_seen <= points_seen + 1'b1;
            out_res     <= mk_res(IDX_W'(hit_k), 1'b1, CNT_W'(distinct_seen), ST_OK);
            state       <= S_IDLE;
          end else if (search_last) begin
            points_seen   <= points_seen + 1'b1;
            distinct_seen <= distinct_seen + 1'b1;
            out_res       <= mk_res(IDX_W'(distinct_seen), 1'b0,
                                    CNT_W'(distinct_seen + CW'(1)), ST_OK);
            state         <= S_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        S_REMAP: begin
          out_res   <= mk_res(rm_rdata, 1'b0, CNT_W'(distinct_seen), ST_OK);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/vertex_dedup_reindex.sv]
// Top level of the exact-duplicate vertex removal and reindex block
//
// Points of one mesh level are added one per transaction and compared for exact
// equality with the distinct points stored so far; a match returns the compact
// index of the first equal point with the duplicate flag, otherwise the point is
// appended under the next compact index. Remap turns an original point index into
// its compact index, clear starts a new level. A two-entry command queue takes
// input transactions while the back end works and a result waits. In the back
// end an add compares the point with the stored distinct points through the
// four-bank point store, one row of four points per cycle, until a match or
// the last row; an add to an empty level appends without a search. Remap reads
// the remap table first; clear, a full-table add, an out-of-range remap and the
// unused code finish when taken. The result register is loaded at the edge that
// ends the back-end work. An accepted transaction is registered in the command
// queue before the back end can take it, and the back end takes a command only
// while the result register is free or being popped. There is no clearing pass.
module vertex_dedup_reindex import vdr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_take;
  logic    out_valid;

  // Accept and classify transactions
  vdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Carry out commands and hold the result
  vdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_res   (result),
    .out_pop   (pop && out_valid)
  );

  assign empty = !out_valid;

endmodule

[rtl/core/vdr_check.sv]
// Port-level checker of the vertex dedup block, bound to the top level
`include "vertex_dedup_reindex_assert.svh"

module vdr_check import vdr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // Both queue sides come out of reset empty
  `VDR_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, empty && !full, "not empty after reset")

  // A waiting result holds until taken
  `VDR_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(result), "result changed while stalled")

  // A duplicate is always a successful add
  `VDR_ASSERT_NOW(a_dup_ok, clk, rst, !empty && result.is_duplicate, result.status == ST_OK, "duplicate with error status")

  // A full-table add returns index zero and no duplicate
  `VDR_ASSERT_NOW(a_full_zero, clk, rst, !empty && (result.status == ST_FULL), (result.new_index == '0) && !result.is_duplicate, "full-table result not cleared")

endmodule

bind vertex_dedup_reindex vdr_check u_check (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

[bench/vertex_dedup_reindex_checker.sv]
// Checker for vertex_dedup_reindex: predicts each result on acceptance and compares it when popped
module vertex_dedup_reindex_checker import vdr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  item_t   item,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  output int      fail_count,
  output int      pending,
  output int      adds_seen,
  output int      dups_seen,
  output int      full_seen,
  output int      remaps_seen,
  output int      range_seen,
  output int      clears_seen,
  output int      peak_distinct
);

  localparam int MAX_REPORTS = 10;

  // Distinct points of the current level and the original-to-compact numbering
  logic [COORD_W-1:0] store_x [MAX_POINTS];
  logic [COORD_W-1:0] store_y [MAX_POINTS];
  logic [COORD_W-1:0] store_z [MAX_POINTS];
  logic [IDX_W-1:0]   orig_to_compact [MAX_POINTS];
  int                 n_points;
  int                 n_distinct;
  int                 n_checked;

  result_t expected_results [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    adds_seen     = 0;
    dups_seen     = 0;
    full_seen     = 0;
    remaps_seen   = 0;
    range_seen    = 0;
    clears_seen   = 0;
    peak_distinct = 0;
    n_checked     = 0;
    n_points      = 0;
    n_distinct    = 0;
  end

  // Apply one input transaction to the level state and return the result it yields
  function automatic result_t expected_reindex(input item_t it);
    result_t r;
    int      k;
    int      found;
    bit      hit;
    r     = '0;
    hit   = 1'b0;
    found = 0;
    case (it.operation)
      OP_ADD: begin
        adds_seen++;
        if (n_points >= MAX_POINTS) begin
          r.status = ST_FULL;
          full_seen++;
        end else begin
          // search every stored point; the first exact match wins
          for (k = 0; k < n_distinct; k++) begin
            if (!hit && store_x[k] == it.pos_x && store_y[k] == it.pos_y &&
                store_z[k] == it.pos_z) begin
              hit   = 1'b1;
              found = k;
            end
          end
          if (!hit) begin
            found            = n_distinct;
            store_x[found]   = it.pos_x;
            store_y[found]   = it.pos_y;
            store_z[found]   = it.pos_z;
            n_distinct++;
          end else begin
            dups_seen++;
          end
          orig_to_compact[n_points] = found[IDX_W-1:0];
          n_points++;
          r.new_index    = found[IDX_W-1:0];
          r.is_duplicate = hit;
        end
      end
      OP_REMAP: begin
        remaps_seen++;
        if (int'(it.orig_index) >= n_points) begin
          r.status = ST_RANGE;
          range_seen++;
        end else begin
          r.new_index = orig_to_compact[it.orig_index];
        end
      end
      OP_CLEAR: begin
        clears_seen++;
        n_points   = 0;
        n_distinct = 0;
      end
      default: ;
    endcase
    if (n_distinct > peak_distinct) peak_distinct = n_distinct;
    r.distinct_count = n_distinct[CNT_W-1:0];
    return r;
  endfunction

  // Check the result transaction first, then queue the prediction for a new input one
  always @(posedge clk) begin : watch
    result_t want;
    logic    bad;
    if (rst) begin
      n_points   = 0;
      n_distinct = 0;
      expected_results.delete();
    end else begin
      if (pop && !empty) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result %0d: new_index %0d is_duplicate %0b distinct_count %0d status %0d",
                     n_checked, result.new_index, result.is_duplicate,
                     result.distinct_count, result.status);
        end else begin
          want = expected_results.pop_front();
          bad  = (result.new_index !== want.new_index) ||
                 (result.is_duplicate !== want.is_duplicate) ||
                 (result.distinct_count !== want.distinct_count) ||
                 (result.status !== want.status);
          if (bad) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch on result %0d: new_index exp %0d got %0d, is_duplicate exp %0b got %0b, distinct_count exp %0d got %0d, status exp %0d got %0d",
                       n_checked, want.new_index, result.new_index,
                       want.is_duplicate, result.is_duplicate,
                       want.distinct_count, result.distinct_count,
                       want.status, result.status);
          end
        end
      end
      if (push && !full) expected_results.push_back(expected_reindex(item));
    end
    pending = expected_results.size();
  end

endmodule

[bench/tb_vertex_dedup_reindex.sv]
// Testbench top for vertex_dedup_reindex: clock, reset, stimulus, receiver pacing and verdict
module tb_vertex_dedup_reindex;
  import vdr_pkg::*;

  localparam int RANDOM_ITEMS   = 500;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES    = 200;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [COORD_W-1:0] C_MAX  = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [COORD_W-1:0] C_ZERO = 32'h0000_0000;
  localparam logic [COORD_W-1:0] C_ONES = 32'hffff_ffff;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  int fail_count, pending, adds_seen, dups_seen, full_seen;
  int remaps_seen, range_seen, clears_seen, peak_distinct;

  // Stimulus-side view of the level, used only to aim remaps and duplicates
  item_t level_points [$];
  int    level_seen;
  int    burst_left;
  int    n_offered;

  vertex_dedup_reindex u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  vertex_dedup_reindex_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .fail_count    (fail_count),
    .pending       (pending),
    .adds_seen     (adds_seen),
    .dups_seen     (dups_seen),
    .full_seen     (full_seen),
    .remaps_seen   (remaps_seen),
    .range_seen    (range_seen),
    .clears_seen   (clears_seen),
    .peak_distinct (peak_distinct)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic item_t mk_item(input logic [1:0] op, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                    input logic [IDX_W-1:0] oi);
    item_t it;
    it.operation  = op;
    it.pos_x      = x;
    it.pos_y      = y;
    it.pos_z      = z;
    it.orig_index = oi;
    return it;
  endfunction

  // Coordinate with extremes mixed in; plain gives a fully random word
  function automatic logic [COORD_W-1:0] rand_coord(input bit plain);
    if (plain) return $urandom;
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return C_ZERO;
      3:       return C_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Offer one input transaction; idle first when the current burst is spent
  task automatic offer(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 24);
    end
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    burst_left--;
    n_offered++;
    if (it.operation == OP_ADD && level_seen < MAX_POINTS) begin
      level_seen++;
      level_points.push_back(it);
    end else if (it.operation == OP_CLEAR) begin
      level_seen = 0;
      level_points.delete();
    end
  endtask

  // One level: clear, then adds with reuse and near misses, remaps and the odd spare code
  task automatic run_level(input bit big, input int n_ops);
    item_t p;
    int    r;
    int    b;
    offer(mk_item(OP_CLEAR, $urandom, $urandom, $urandom, 8'($urandom)));
    if (big) begin
      // fill the table with distinct points, then push past the limit
      while (level_seen < MAX_POINTS) begin
        if ($urandom_range(0, 99) < 85)
          offer(mk_item(OP_ADD, rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1),
                        8'($urandom)));
        else
          offer(mk_item(OP_REMAP, $urandom, $urandom, $urandom,
                        8'($urandom_range(0, level_seen - 1))));
      end
      repeat (20) begin
        if ($urandom_range(0, 99) < 60)
          offer(mk_item(OP_ADD, rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1),
                        8'($urandom)));
        else
          offer(mk_item(OP_REMAP, $urandom, $urandom, $urandom,
                        ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom)));
      end
    end else begin
      repeat (n_ops) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          b = $urandom_range(0, 99);
          if (level_points.size() > 0 && b < 45) begin
            p = level_points[$urandom_range(0, level_points.size() - 1)];
            p.orig_index = 8'($urandom);
            // near miss: flip one bit of one coordinate
            if (b >= 35) begin
              b = $urandom_range(0, COORD_W - 1);
              case ($urandom_range(0, 2))
                0:       p.pos_x[b] = ~p.pos_x[b];
                1:       p.pos_y[b] = ~p.pos_y[b];
                default: p.pos_z[b] = ~p.pos_z[b];
              endcase
            end
            offer(p);
          end else begin
            offer(mk_item(OP_ADD, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                          8'($urandom)));
          end
        end else if (r < 90) begin
          if (level_seen > 0 && $urandom_range(0, 4) != 0)
            offer(mk_item(OP_REMAP, $urandom, $urandom, $urandom,
                          8'($urandom_range(0, level_seen - 1))));
          else
            offer(mk_item(OP_REMAP, $urandom, $urandom, $urandom, 8'($urandom)));
        end else if (r < 95) begin
          offer(mk_item(OP_NONE, $urandom, $urandom, $urandom, 8'($urandom)));
        end else begin
          offer(mk_item(OP_CLEAR, $urandom, $urandom, $urandom, 8'($urandom)));
        end
      end
    end
  endtask

  // Receiver: pop on a changing pattern, with two long hold-offs to back the block up
  initial begin : rx_side
    int mode;
    int mode_left;
    int popped;
    bit hold;
    pop <= 1'b0;
    mode      = 0;
    mode_left = 0;
    popped    = 0;
    forever begin
      @(posedge clk);
      hold = 1'b0;
      if (pop && !empty) begin
        popped++;
        if (popped == 40 || popped == 300) hold = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 200);
      end
      mode_left--;
      if (rst) begin
        pop <= 1'b0;
      end else if (hold) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int base;
    int lvl;
    rst        <= 1'b1;
    push       <= 1'b0;
    item       <= '0;
    level_seen = 0;
    burst_left = 0;
    n_offered  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-level remaps, extreme points, duplicates, near miss, spare code, clear
    offer(mk_item(OP_REMAP, $urandom, $urandom, $urandom, 8'd0));
    offer(mk_item(OP_REMAP, $urandom, $urandom, $urandom, 8'd255));
    offer(mk_item(OP_ADD, C_ZERO, C_ZERO, C_ZERO, 8'd0));
    offer(mk_item(OP_ADD, C_MAX, C_MAX, C_MAX, 8'd255));
    offer(mk_item(OP_ADD, C_MIN, C_MIN, C_MIN, 8'd0));
    offer(mk_item(OP_ADD, C_ZERO, C_ZERO, C_ZERO, 8'd255));
    offer(mk_item(OP_ADD, C_MIN, C_MIN, C_MAX, 8'd0));
    offer(mk_item(OP_ADD, C_ONES, C_ONES, C_ONES, 8'd255));
    offer(mk_item(OP_ADD, C_MAX, C_MAX, C_MAX, 8'd0));
    offer(mk_item(OP_ADD, C_MIN, C_MIN, C_MAX, 8'd0));
    offer(mk_item(OP_REMAP, C_ZERO, C_ZERO, C_ZERO, 8'd0));
    offer(mk_item(OP_REMAP, C_ONES, C_ONES, C_ONES, 8'd3));
    offer(mk_item(OP_REMAP, C_ZERO, C_ZERO, C_ZERO, 8'd6));
    offer(mk_item(OP_REMAP, C_ZERO, C_ZERO, C_ZERO, 8'd7));
    offer(mk_item(OP_REMAP, C_ZERO, C_ZERO, C_ZERO, 8'd8));
    offer(mk_item(OP_NONE, C_ONES, C_ONES, C_ONES, 8'd255));
    offer(mk_item(OP_CLEAR, C_ZERO, C_ZERO, C_ZERO, 8'd0));
    offer(mk_item(OP_REMAP, C_ZERO, C_ZERO, C_ZERO, 8'd0));
    offer(mk_item(OP_ADD, C_MIN, C_MIN, C_MIN, 8'd0));
    offer(mk_item(OP_REMAP, C_ZERO, C_ZERO, C_ZERO, 8'd0));

    // random levels; the second one fills the table
    base = n_offered;
    lvl  = 0;
    while (n_offered - base < RANDOM_ITEMS) begin
      run_level(lvl == 1, $urandom_range(4, 40));
      lvl++;
    end
    push <= 1'b0;

    // drain, then watch a while for stray results
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d transactions over %0d levels: %0d adds", n_offered, lvl, adds_seen);
    $display("(%0d duplicates, %0d into a full table), %0d remaps (%0d out of range)",
             dups_seen, full_seen, remaps_seen, range_seen);
    $display("%0d clears, peak distinct count %0d, %0d failures",
             clears_seen, peak_distinct, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
